// File: hdl/depth_label_colour_propagation_defines.svh
// Assertion macros shared by the checker of the depth label colour propagation block.
// No dependencies.
`ifndef DEPTH_LABEL_COLOUR_PROPAGATION_DEFINES_SVH
`define DEPTH_LABEL_COLOUR_PROPAGATION_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define DLCP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DLCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/dlcp_pkg.sv
// Package of the depth label colour propagation block: sizes, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package dlcp_pkg;
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned StoreSize = MaxWidth * MaxHeight;
  localparam int unsigned AddrW     = $clog2(StoreSize);
  localparam int unsigned DimW      = 9;
  localparam logic [23:0] ColourKeep = 24'hfcfcfc;
  localparam logic [31:0] FrameField = 32'h0000ff00;
  localparam logic [31:0] RoundHalf  = 32'd128;

  typedef enum logic [1:0] {
    KIND_LOAD_DEPTH  = 2'd0,
    KIND_LOAD_COLOUR = 2'd1,
    KIND_READ        = 2'd2,
    KIND_NONE        = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_DMASK  = 2'd2,
    REG_EMASK  = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    OP_LOAD_DEPTH, OP_LOAD_COLOUR, OP_READ, OP_PASSES
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] addr;
    logic        in_range;
    logic [31:0] word;
    logic [23:0] colour;
    logic [7:0]  frame;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_NB, ST_RD_ME, ST_EVAL, ST_NEXT, ST_RESULT
  } state_e;
endpackage

// File: hdl/dlcp_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module dlcp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// File: hdl/dlcp_front.sv
// Front end: accepts input transactions, classifies them into commands, queues them.
// Depends on dlcp_pkg.
`timescale 1ns / 1ps
module dlcp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [1:0]         kind_i,
  input  logic [15:0]        pixel_addr_i,
  input  logic [31:0]        depth_word_in_i,
  input  logic [23:0]        colour_i,
  input  logic [7:0]         frame_number_i,
  input  logic               last_pixel_i,
  output logic               cmd_valid_o,
  input  logic               cmd_take_i,
  output dlcp_pkg::cmd_t     cmd_o
);
  // two-entry command queue
  dlcp_pkg::cmd_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       enq, deq, keep;
  dlcp_pkg::cmd_t c;
  dlcp_pkg::kind_e k;

  always_comb begin
    k          = dlcp_pkg::kind_e'(kind_i);
    c.addr     = pixel_addr_i;
    c.in_range = ({1'b0, pixel_addr_i} < 17'(dlcp_pkg::StoreSize));
    c.word     = depth_word_in_i;
    c.colour   = colour_i;
    c.frame    = frame_number_i;
    c.op       = dlcp_pkg::OP_READ;
    keep       = 1'b1;
    unique case (k)
      dlcp_pkg::KIND_LOAD_DEPTH:  c.op = dlcp_pkg::OP_LOAD_DEPTH;
      dlcp_pkg::KIND_LOAD_COLOUR: c.op = last_pixel_i ? dlcp_pkg::OP_PASSES
                                                      : dlcp_pkg::OP_LOAD_COLOUR;
      dlcp_pkg::KIND_READ:        c.op = dlcp_pkg::OP_READ;
      default:                    keep = 1'b0;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_q];
  assign enq         = push_i && !full_o && keep;
  assign deq         = cmd_take_i && cmd_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (enq && !deq) cnt_d = cnt_q + 2'd1;
    if (!enq && deq) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (enq) wr_q <= ~wr_q;
      if (deq) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) q_q[wr_q] <= c;
  end
endmodule

// File: hdl/dlcp_back.sv
// Back end: executes commands on depth and colour memories, runs the four scan passes.
// Depends on dlcp_pkg and dlcp_ram.
`timescale 1ns / 1ps
module dlcp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_take_o,
  input  dlcp_pkg::cmd_t      cmd_i,
  input  logic [8:0]          width_i,
  input  logic [8:0]          height_i,
  input  logic [31:0]         dmask_i,
  input  logic [31:0]         emask_i,
  output logic                res_valid_o,
  input  logic                res_take_i,
  output logic [31:0]         res_word_o,
  output logic [15:0]         res_addr_o,
  output logic                res_done_o
);
  localparam int unsigned AW = dlcp_pkg::AddrW;
  localparam int unsigned CW = $clog2(dlcp_pkg::MaxWidth) + 1;
  localparam int unsigned RW = $clog2(dlcp_pkg::MaxHeight) + 1;

  dlcp_pkg::state_e st_q, st_d;
  logic [1:0]  pass_q, pass_d;
  logic [CW-1:0] x_q, x_d;
  logic [RW-1:0] y_q, y_d;
  logic [7:0]  frame_q, frame_d;
  logic [31:0] nbw_q, nbw_d;
  logic [23:0] nbc_q, nbc_d;
  logic        rv_q, rv_d, done_q, done_d;
  logic [31:0] rw_q, rw_d;
  logic [15:0] ra_q, ra_d;
  logic        rinside_q, rinside_d;

  logic [CW-1:0] w;
  logic [RW-1:0] h;
  logic [AW-1:0] here, from, maddr;
  logic [AW+1:0] lin;
  logic          dwe, cwe;
  logic [31:0]   dwd, drd;
  logic [23:0]   cwd, crd;
  logic [31:0]   fr;
  logic          hit, last_pos;

  // clamp dimensions
  always_comb begin
    if (width_i < 9'd2) w = CW'(2);
    else if (width_i > 9'(dlcp_pkg::MaxWidth)) w = CW'(dlcp_pkg::MaxWidth);
    else w = CW'(width_i);
    if (height_i < 9'd2) h = RW'(2);
    else if (height_i > 9'(dlcp_pkg::MaxHeight)) h = RW'(dlcp_pkg::MaxHeight);
    else h = RW'(height_i);
  end

  // here/from addresses: y*w + x, one narrow multiply
  always_comb begin
    lin  = (AW+2)'(y_q) * (AW+2)'(w) + (AW+2)'(x_q);
    here = lin[AW-1:0];
    from = here;
    unique case (pass_q)
      2'd0: from = here - AW'(1);
      2'd1: from = here + AW'(1);
      2'd2: from = here - AW'(w);
      default: from = here + AW'(w);
    endcase
  end

  dlcp_ram #(.Width(32), .Depth(dlcp_pkg::StoreSize)) u_depth (
    .clk_i(clk_i), .we_i(dwe), .addr_i(maddr), .wdata_i(dwd), .rdata_o(drd));
  dlcp_ram #(.Width(24), .Depth(dlcp_pkg::StoreSize)) u_colour (
    .clk_i(clk_i), .we_i(cwe), .addr_i(maddr), .wdata_i(cwd), .rdata_o(crd));

  assign fr  = ((nbw_q & dmask_i) + dlcp_pkg::RoundHalf) & dlcp_pkg::FrameField;
  assign hit = (fr == {16'd0, frame_q, 8'd0}) && ((drd & emask_i) != 0)
            && ((nbw_q & emask_i) == 0)
            && ((nbc_q & dlcp_pkg::ColourKeep) == (crd & dlcp_pkg::ColourKeep));

  // end of the scan for the current pass
  always_comb begin
    unique case (pass_q)
      2'd0: last_pos = (x_q == w - CW'(1)) && (y_q == h - RW'(1));
      2'd1: last_pos = (x_q == CW'(0)) && (y_q == h - RW'(1));
      2'd2: last_pos = (y_q == h - RW'(1)) && (x_q == w - CW'(1));
      default: last_pos = (y_q == RW'(0)) && (x_q == w - CW'(1));
    endcase
  end

  assign res_valid_o = rv_q;
  assign res_word_o  = rw_q;
  assign res_addr_o  = ra_q;
  assign res_done_o  = done_q;

  always_comb begin
    st_d = st_q; pass_d = pass_q; x_d = x_q; y_d = y_q; frame_d = frame_q;
    nbw_d = nbw_q; nbc_d = nbc_q; rv_d = rv_q; rw_d = rw_q; ra_d = ra_q;
    done_d = done_q; rinside_d = rinside_q;
    dwe = 1'b0; cwe = 1'b0; dwd = cmd_i.word; cwd = cmd_i.colour;
    maddr = cmd_i.addr[AW-1:0]; cmd_take_o = 1'b0;
    if (rv_q && res_take_i) rv_d = 1'b0;
    unique case (st_q)
      dlcp_pkg::ST_IDLE: begin
        if (cmd_valid_i && !rv_q) begin
          cmd_take_o = 1'b1;
          unique case (cmd_i.op)
            dlcp_pkg::OP_LOAD_DEPTH:  dwe = cmd_i.in_range;
            dlcp_pkg::OP_LOAD_COLOUR: cwe = cmd_i.in_range;
            dlcp_pkg::OP_READ: begin
              ra_d = cmd_i.addr; rinside_d = cmd_i.in_range;
              st_d = dlcp_pkg::ST_RESULT;
            end
            default: begin
              cwe = cmd_i.in_range; frame_d = cmd_i.frame;
              pass_d = 2'd0; x_d = CW'(1); y_d = '0;
              st_d = dlcp_pkg::ST_RD_NB;
            end
          endcase
        end
      end
      dlcp_pkg::ST_RD_NB: begin
        maddr = from; st_d = dlcp_pkg::ST_RD_ME;
      end
      dlcp_pkg::ST_RD_ME: begin
        maddr = here; nbw_d = drd; nbc_d = crd; st_d = dlcp_pkg::ST_EVAL;
      end
      dlcp_pkg::ST_EVAL: begin
        maddr = here; dwe = hit; dwd = nbw_q; st_d = dlcp_pkg::ST_NEXT;
      end
      dlcp_pkg::ST_NEXT: begin
        st_d = dlcp_pkg::ST_RD_NB;
        if (last_pos) begin
          pass_d = pass_q + 2'd1;
          unique case (pass_q)
            2'd0: begin x_d = w - CW'(2); y_d = '0; end
            2'd1: begin x_d = '0; y_d = RW'(1); end
            2'd2: begin x_d = '0; y_d = h - RW'(2); end
            default: begin
              rw_d = '0; ra_d = '0; done_d = 1'b1; rv_d = 1'b1;
              st_d = dlcp_pkg::ST_IDLE;
            end
          endcase
        end else begin
          unique case (pass_q)
            2'd0: if (x_q == w - CW'(1)) begin x_d = CW'(1); y_d = y_q + RW'(1); end
                  else x_d = x_q + CW'(1);
            2'd1: if (x_q == CW'(0)) begin x_d = w - CW'(2); y_d = y_q + RW'(1); end
                  else x_d = x_q - CW'(1);
            2'd2: if (y_q == h - RW'(1)) begin y_d = RW'(1); x_d = x_q + CW'(1); end
                  else y_d = y_q + RW'(1);
            default: if (y_q == RW'(0)) begin y_d = h - RW'(2); x_d = x_q + CW'(1); end
                     else y_d = y_q - RW'(1);
          endcase
        end
      end
      dlcp_pkg::ST_RESULT: begin
        rw_d = rinside_q ? drd : '0; done_d = 1'b0; rv_d = 1'b1;
        st_d = dlcp_pkg::ST_IDLE;
      end
      default: st_d = dlcp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= dlcp_pkg::ST_IDLE;
      rv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q <= pass_d; x_q <= x_d; y_q <= y_d; frame_q <= frame_d;
    nbw_q <= nbw_d; nbc_q <= nbc_d; rw_q <= rw_d; ra_q <= ra_d;
    done_q <= done_d; rinside_q <= rinside_d;
  end
endmodule

// File: hdl/depth_label_colour_propagation.sv
// Top level of the depth label colour propagation block.
// Depends on dlcp_pkg, dlcp_front, dlcp_back (which uses dlcp_ram).
//
// Usage:
// - Input queue: drive kind/pixel_addr/depth_word_in/colour/frame_number/
//   last_pixel and raise push; a transaction is taken when full is low.
// - Result queue: while empty is low the result fields are valid; pop
//   takes the transaction.
// - Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   write only while the block is idle.
// Flow:
// - Loads are written to memory as the back end takes them; a read result
//   passes the command queue, memory read register and result register.
// - A last-pixel item runs four scan passes; each visited pixel steps
//   through the neighbour read, own read, write and advance states, as the
//   scan shares the single memory port between neighbour read, own read and write.
// - A two-entry command queue parts front and back, and a result register
//   parts the back end from the result port.
// Reset: clears control state and loads the register reset values; the
//   memories hold nothing defined until written.
// Stall: when the result is not popped, the back end holds and the command
//   queue fills, then full rises.
`timescale 1ns / 1ps
module depth_label_colour_propagation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [15:0] pixel_addr_i,
  input  logic [31:0] depth_word_in_i,
  input  logic [23:0] colour_i,
  input  logic [7:0]  frame_number_i,
  input  logic        last_pixel_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] depth_word_out_o,
  output logic [15:0] read_addr_o,
  output logic        passes_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  logic [8:0]  width_q, height_q;
  logic [31:0] dmask_q, emask_q;
  logic        cmd_valid, cmd_take, res_valid;
  dlcp_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // register file: decode the index and hold each register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      dmask_q  <= 32'h0000ffff;
      emask_q  <= 32'h40000000;
    end else if (cfg_valid_i) begin
      unique case (dlcp_pkg::reg_e'(cfg_index_i))
        dlcp_pkg::REG_WIDTH:  width_q  <= cfg_data_i[8:0];
        dlcp_pkg::REG_HEIGHT: height_q <= cfg_data_i[8:0];
        dlcp_pkg::REG_DMASK:  dmask_q  <= cfg_data_i;
        default:              emask_q  <= cfg_data_i;
      endcase
    end
  end

  dlcp_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .kind_i, .pixel_addr_i,
    .depth_word_in_i, .colour_i, .frame_number_i, .last_pixel_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd));

  dlcp_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .width_i(width_q), .height_i(height_q), .dmask_i(dmask_q), .emask_i(emask_q),
    .res_valid_o(res_valid), .res_take_i(pop), .res_word_o(depth_word_out_o),
    .res_addr_o(read_addr_o), .res_done_o(passes_done_o));

  assign empty = !res_valid;
endmodule

// File: hdl/dlcp_checker.sv
// Port-level checker for the depth label colour propagation block, bound to the top.
// Depends on depth_label_colour_propagation_defines.svh.
`timescale 1ns / 1ps
`include "depth_label_colour_propagation_defines.svh"
module dlcp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        passes_done_o,
  input logic [31:0] depth_word_out_o,
  input logic [15:0] read_addr_o
);
  logic zero_out;

  assign zero_out = (depth_word_out_o == 32'd0) && (read_addr_o == 16'd0);

  `DLCP_ASSERT_IMPL(a_done_zero, clk_i, rst_ni, !empty && passes_done_o, zero_out)
  `DLCP_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(depth_word_out_o))
  `DLCP_ASSERT_NEXT(a_pop_gap, clk_i, rst_ni, !empty && pop, empty)
endmodule

bind depth_label_colour_propagation dlcp_checker u_checker (
  .clk_i, .rst_ni, .empty, .pop, .passes_done_o, .depth_word_out_o, .read_addr_o);
